[hw/rtl/bs3d_pkg.sv]
// Shared constants, types and helper functions of the 27-point box stencil.
`default_nettype none
package bs3d_pkg;

   localparam int MAX_X = 64;
   localparam int MAX_Y = 64;
   localparam int MAX_Z = 1024;
   localparam int NCOEF = 27;

   localparam int X_W = $clog2(MAX_X);
   localparam int Y_W = $clog2(MAX_Y);
   localparam int Z_W = $clog2(MAX_Z);
   localparam int PLANE_DEPTH = MAX_X * MAX_Y;
   localparam int PLANE_AW = X_W + Y_W;
   localparam int CIDX_W = 5;
   localparam int DATA_W = 32;
   localparam int PROD_W = 2 * DATA_W;
   localparam int SUM9_W = PROD_W + 2;
   localparam int SUM3_W = PROD_W + 4;
   localparam int SIZE_W = 11;

   typedef enum logic [1:0] {
      REG_SIZE_X = 2'd0,
      REG_SIZE_Y = 2'd1,
      REG_SIZE_Z = 2'd2,
      REG_NONE   = 2'd3
   } csr_index_type;

   typedef enum logic {
      CMD_LOAD_COEF = 1'b0,
      CMD_SAMPLE    = 1'b1
   } command_type;

   typedef logic signed [DATA_W-1:0] window_type [3][3][3];
   typedef logic signed [DATA_W-1:0] coef_type [NCOEF];

   typedef struct packed {
      logic [X_W-1:0] cx;
      logic [Y_W-1:0] cy;
      logic [Z_W-1:0] cz;
      logic           last;
   } meta_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      meta_type                 meta;
   } rsp_type;

   // Clamp a programmed extent into the range 3..maxv.
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                  input logic [SIZE_W-1:0] maxv);
      logic [SIZE_W-1:0] r;
      if (v < SIZE_W'(3)) r = SIZE_W'(3);
      else if (v > maxv) r = maxv;
      else r = v;
      return r;
   endfunction

   // Coefficient number for window plane d, row i, column j. Plane and row
   // indexes count backward from the newest sample, column forward.
   function automatic logic [CIDX_W-1:0] coef_sel(input int d, input int i, input int j);
      int k;
      k = 1 + 9 * j + 3 * (2 - i) + (2 - d);
      if (d == 1 && i == 1 && j == 1) k = 0;
      else if (k > 14) k = k - 1;
      return CIDX_W'(k);
   endfunction

endpackage
`default_nettype wire

[hw/rtl/bs3d_window.sv]
// Plane and line buffers that feed a 3x3x3 sliding window of samples.
`default_nettype none
module bs3d_window (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 rd_en,
   input  wire [bs3d_pkg::X_W-1:0]             rd_x,
   input  wire [bs3d_pkg::Y_W-1:0]             rd_y,
   input  wire signed [bs3d_pkg::DATA_W-1:0]   rd_sample,
   output bs3d_pkg::window_type                window_out
);

   logic                               s1_valid_ff;
   logic [bs3d_pkg::X_W-1:0]           s1_x_ff;
   logic [bs3d_pkg::Y_W-1:0]           s1_y_ff;
   logic signed [bs3d_pkg::DATA_W-1:0] s1_sample_ff;

   logic signed [bs3d_pkg::DATA_W-1:0] plane1_mem [bs3d_pkg::PLANE_DEPTH];
   logic signed [bs3d_pkg::DATA_W-1:0] plane2_mem [bs3d_pkg::PLANE_DEPTH];
   logic signed [bs3d_pkg::DATA_W-1:0] line1_mem [3][bs3d_pkg::MAX_X];
   logic signed [bs3d_pkg::DATA_W-1:0] line2_mem [3][bs3d_pkg::MAX_X];

   logic signed [bs3d_pkg::DATA_W-1:0] p1_rd_ff;
   logic signed [bs3d_pkg::DATA_W-1:0] p2_rd_ff;
   logic signed [bs3d_pkg::DATA_W-1:0] l1_rd_ff [3];
   logic signed [bs3d_pkg::DATA_W-1:0] l2_rd_ff [3];

   logic signed [bs3d_pkg::DATA_W-1:0] col_in [3][3];
   bs3d_pkg::window_type               window_ff;

   wire [bs3d_pkg::PLANE_AW-1:0] rd_addr = {rd_y, rd_x};
   wire [bs3d_pkg::PLANE_AW-1:0] wr_addr = {s1_y_ff, s1_x_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_x_ff <= rd_x;
         s1_y_ff <= rd_y;
         s1_sample_ff <= rd_sample;
      end
   end

   // Each buffer is read when a sample is accepted and written in the following
   // cycle; consecutive samples never share an address.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         p1_rd_ff <= plane1_mem[rd_addr];
         p2_rd_ff <= plane2_mem[rd_addr];
      end
      if (s1_valid_ff) begin
         plane1_mem[wr_addr] <= s1_sample_ff;
         plane2_mem[wr_addr] <= p1_rd_ff;
      end
   end

   for (genvar d = 0; d < 3; d++) begin : g_line
      always_ff @(posedge clock) begin
         if (rd_en) begin
            l1_rd_ff[d] <= line1_mem[d][rd_x];
            l2_rd_ff[d] <= line2_mem[d][rd_x];
         end
         if (s1_valid_ff) begin
            line1_mem[d][s1_x_ff] <= col_in[d][0];
            line2_mem[d][s1_x_ff] <= l1_rd_ff[d];
         end
      end
   end

   // New column: plane offset d and row offset i behind the newest sample.
   always_comb begin
      col_in[0][0] = s1_sample_ff;
      col_in[1][0] = p1_rd_ff;
      col_in[2][0] = p2_rd_ff;
      for (int d = 0; d < 3; d++) begin
         col_in[d][1] = l1_rd_ff[d];
         col_in[d][2] = l2_rd_ff[d];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         for (int d = 0; d < 3; d++) begin
            for (int i = 0; i < 3; i++) begin
               window_ff[d][i][0] <= window_ff[d][i][1];
               window_ff[d][i][1] <= window_ff[d][i][2];
               window_ff[d][i][2] <= col_in[d][i];
            end
         end
      end
   end

   assign window_out = window_ff;

endmodule
`default_nettype wire

[hw/rtl/bs3d_mac.sv]
// Multiplies the window by the coefficients and reduces the products.
`default_nettype none
module bs3d_mac (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   input  bs3d_pkg::meta_type   in_meta,
   input  bs3d_pkg::window_type window,
   input  bs3d_pkg::coef_type   coef,
   output logic                 out_valid,
   output bs3d_pkg::rsp_type    out_rsp
);

   logic [3:0]                           valid_ff;
   bs3d_pkg::meta_type                   meta_ff [3];
   logic signed [bs3d_pkg::PROD_W-1:0]   prod_ff [27];
   logic signed [bs3d_pkg::SUM9_W-1:0]   sum9_ff [9];
   logic signed [bs3d_pkg::SUM3_W-1:0]   sum3_ff [3];
   logic signed [bs3d_pkg::SUM3_W-1:0]   total;
   logic signed [bs3d_pkg::SUM3_W-1:0]   shifted;
   logic signed [bs3d_pkg::DATA_W-1:0]   sat;
   bs3d_pkg::rsp_type                    rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      meta_ff[0] <= in_meta;
      for (int s = 1; s < 3; s++) begin
         meta_ff[s] <= meta_ff[s-1];
      end
      for (int d = 0; d < 3; d++) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[9*d + 3*i + j] <= window[d][i][j] *
                  coef[bs3d_pkg::coef_sel(d, i, j)];
            end
         end
      end
      for (int n = 0; n < 9; n++) begin
         sum9_ff[n] <= bs3d_pkg::SUM9_W'(prod_ff[3*n]) +
                       bs3d_pkg::SUM9_W'(prod_ff[3*n + 1]) +
                       bs3d_pkg::SUM9_W'(prod_ff[3*n + 2]);
      end
      for (int n = 0; n < 3; n++) begin
         sum3_ff[n] <= bs3d_pkg::SUM3_W'(sum9_ff[3*n]) +
                       bs3d_pkg::SUM3_W'(sum9_ff[3*n + 1]) +
                       bs3d_pkg::SUM3_W'(sum9_ff[3*n + 2]);
      end
      rsp_ff.value <= sat;
      rsp_ff.meta <= meta_ff[2];
   end

   // Round Q32.32 to nearest with ties upward, then saturate to 32 bits.
   always_comb begin
      total = sum3_ff[0] + sum3_ff[1] + sum3_ff[2];
      shifted = (total + bs3d_pkg::SUM3_W'(32768)) >>> 16;
      if (shifted > bs3d_pkg::SUM3_W'(64'sd2147483647)) begin
         sat = 32'sh7FFF_FFFF;
      end else if (shifted < -bs3d_pkg::SUM3_W'(64'sd2147483648)) begin
         sat = 32'sh8000_0000;
      end else begin
         sat = shifted[bs3d_pkg::DATA_W-1:0];
      end
   end

   assign out_valid = valid_ff[3];
   assign out_rsp = rsp_ff;

endmodule
`default_nettype wire

[hw/rtl/box_stencil_27pt_3d.sv]
// 27-point 3-D box stencil: takes one transaction per clock, coefficient loads or
// raster-order samples, and raises rsp_tvalid with the rounded, saturated weighted sum
// of every interior point, once the sample that completes its window has passed the pipeline. Two
// plane buffers and six line buffers, each with one read and one write a cycle, feed a
// 3x3x3 window; 27 multipliers and a three-level adder tree follow. An eight-entry
// result queue lets input continue while results wait, and input stalls only when eight
// results are in flight or queued. Writing any size register restarts the grid at (0,0,0).
`default_nettype none
module box_stencil_27pt_3d (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [39:0]  req_tdata,   // coef_index[4:0], data_value[36:5], zero fill
   input  wire         req_tuser,   // command
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [55:0] rsp_tdata,   // result_value[31:0], out_x[37:32], out_y[43:38],
                                    // out_z[53:44], zero fill
   output logic        rsp_tlast,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire [1:0]   csr_index,
   input  wire [10:0]  csr_data
);

   localparam int QDEPTH = 8;
   localparam int QAW = $clog2(QDEPTH);

   logic [6:0]                         size_x_ff;
   logic [6:0]                         size_y_ff;
   logic [10:0]                        size_z_ff;
   logic [bs3d_pkg::X_W-1:0]           pos_x_ff, pos_x_in;
   logic [bs3d_pkg::Y_W-1:0]           pos_y_ff, pos_y_in;
   logic [bs3d_pkg::Z_W-1:0]           pos_z_ff, pos_z_in;
   logic [bs3d_pkg::SIZE_W-1:0]        ex, ey, ez;
   logic                               accept, is_sample, produce;
   bs3d_pkg::meta_type                 meta_in;

   logic                               s1_valid_ff, s1_load_ff, s1_produce_ff;
   logic                               s2_valid_ff, s2_load_ff, s2_produce_ff;
   logic [bs3d_pkg::CIDX_W-1:0]        s1_idx_ff, s2_idx_ff;
   logic signed [bs3d_pkg::DATA_W-1:0] s1_data_ff, s2_data_ff;
   bs3d_pkg::meta_type                 s1_meta_ff, s2_meta_ff;
   bs3d_pkg::coef_type                 coef_ff;
   bs3d_pkg::window_type               window;

   logic                               res_valid;
   bs3d_pkg::rsp_type                  res_rsp;
   bs3d_pkg::rsp_type                  queue_ff [QDEPTH];
   logic [QAW-1:0]                     wr_ptr_ff, rd_ptr_ff;
   logic [QAW:0]                       q_count_ff, pending_ff;
   logic                               rsp_take;

   wire [bs3d_pkg::CIDX_W-1:0]        req_idx = req_tdata[4:0];
   wire signed [bs3d_pkg::DATA_W-1:0] req_data = req_tdata[36:5];

   assign csr_ready = 1'b1;
   assign req_tready = (pending_ff < (QAW+1)'(QDEPTH));
   assign accept = req_tvalid && req_tready;
   assign is_sample = (req_tuser == bs3d_pkg::CMD_SAMPLE);

   always_comb begin
      ex = bs3d_pkg::eff_size(11'(size_x_ff), 11'(bs3d_pkg::MAX_X));
      ey = bs3d_pkg::eff_size(11'(size_y_ff), 11'(bs3d_pkg::MAX_Y));
      ez = bs3d_pkg::eff_size(size_z_ff, 11'(bs3d_pkg::MAX_Z));
      produce = is_sample && (pos_x_ff >= 2) && (pos_y_ff >= 2) && (pos_z_ff >= 2);
      meta_in.cx = pos_x_ff - 1'b1;
      meta_in.cy = pos_y_ff - 1'b1;
      meta_in.cz = pos_z_ff - 1'b1;
      meta_in.last = (11'(pos_x_ff) == ex - 11'd1) && (11'(pos_y_ff) == ey - 11'd1) &&
                     (11'(pos_z_ff) == ez - 11'd1);
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      if (11'(pos_x_ff) + 11'd1 >= ex) begin
         pos_x_in = '0;
         if (11'(pos_y_ff) + 11'd1 >= ey) begin
            pos_y_in = '0;
            if (11'(pos_z_ff) + 11'd1 >= ez) begin
               pos_z_in = '0;
            end else begin
               pos_z_in = pos_z_ff + 1'b1;
            end
         end else begin
            pos_y_in = pos_y_ff + 1'b1;
         end
      end else begin
         pos_x_in = pos_x_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= 7'd64;
         size_y_ff <= 7'd64;
         size_z_ff <= 11'd64;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
      end else if (csr_valid && csr_ready && csr_index != bs3d_pkg::REG_NONE) begin
         unique case (csr_index)
            bs3d_pkg::REG_SIZE_X: size_x_ff <= csr_data[6:0];
            bs3d_pkg::REG_SIZE_Y: size_y_ff <= csr_data[6:0];
            default:              size_z_ff <= csr_data;
         endcase
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
      end else if (accept && is_sample) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
      end
   end

   // Loads ride the pipeline so a coefficient changes exactly between the
   // products of the samples before and after it.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_load_ff <= !is_sample;
      s1_produce_ff <= produce;
      s1_idx_ff <= req_idx;
      s1_data_ff <= req_data;
      s1_meta_ff <= meta_in;
      s2_load_ff <= s1_load_ff;
      s2_produce_ff <= s1_produce_ff;
      s2_idx_ff <= s1_idx_ff;
      s2_data_ff <= s1_data_ff;
      s2_meta_ff <= s1_meta_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < bs3d_pkg::NCOEF; k++) begin
            coef_ff[k] <= '0;
         end
      end else if (s2_valid_ff && s2_load_ff &&
                   s2_idx_ff < bs3d_pkg::CIDX_W'(bs3d_pkg::NCOEF)) begin
         coef_ff[s2_idx_ff] <= s2_data_ff;
      end
   end

   bs3d_window u_window (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept && is_sample),
      .rd_x       (pos_x_ff),
      .rd_y       (pos_y_ff),
      .rd_sample  (req_data),
      .window_out (window)
   );

   bs3d_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff && !s2_load_ff && s2_produce_ff),
      .in_meta   (s2_meta_ff),
      .window    (window),
      .coef      (coef_ff),
      .out_valid (res_valid),
      .out_rsp   (res_rsp)
   );

   // Result queue; the pending count covers results still in the pipeline,
   // so a write always finds room.
   assign rsp_take = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         q_count_ff <= '0;
         pending_ff <= '0;
      end else begin
         if (res_valid) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (rsp_take) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         q_count_ff <= q_count_ff + (QAW+1)'(res_valid) - (QAW+1)'(rsp_take);
         pending_ff <= pending_ff + (QAW+1)'(accept && produce) - (QAW+1)'(rsp_take);
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) queue_ff[wr_ptr_ff] <= res_rsp;
   end

   assign rsp_tvalid = (q_count_ff != '0);
   assign rsp_tdata = {2'b00, queue_ff[rd_ptr_ff].meta.cz, queue_ff[rd_ptr_ff].meta.cy,
                       queue_ff[rd_ptr_ff].meta.cx, queue_ff[rd_ptr_ff].value};
   assign rsp_tlast = queue_ff[rd_ptr_ff].meta.last;

endmodule
`default_nettype wire
